// File: rtl/core/averaged_overtemp_alarm_debounce_defines.svh
// assertion macros for the over-temperature alarm block
`ifndef AVERAGED_OVERTEMP_ALARM_DEBOUNCE_DEFINES_SVH
`define AVERAGED_OVERTEMP_ALARM_DEBOUNCE_DEFINES_SVH

`ifndef SYNTHESIS
// checked outside reset
`define AOAD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked on every edge, reset included
`define AOAD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define AOAD_ASSERT(label, clk, rst_n, prop, msg)
`define AOAD_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

// File: rtl/core/aoad_pkg.sv
package aoad_pkg;

  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 32;

  // register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_SAMPLES   = 2'd1;
  localparam logic [1:0] REG_CONFIRM   = 2'd2;

  localparam logic [15:0] THRESHOLD_RST = 16'd23967;
  localparam logic [7:0]  SAMPLES_RST   = 8'd25;
  localparam logic [7:0]  CONFIRM_RST   = 8'd5;

  typedef struct packed {
    logic block_done;
    logic above_limit;
    logic alarm_active;
  } result_t;

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

endpackage

// File: rtl/core/averaged_overtemp_alarm_debounce.sv
// an input transfer passes the input register, then the result register, to the master side
// throughput: one sample per cycle while the master side takes results; the accumulate,
// compare and confirm update of the held state is combinational between both registers
// reset: asynchronous, clears sums, counters and alarm; registers return to
// threshold 23967, block length 25, confirm count 5
`include "averaged_overtemp_alarm_debounce_defines.svh"

module averaged_overtemp_alarm_debounce
  import aoad_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample stream
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [15:0]        s_axis_tdata,  // [15:0] temperature_raw
  // result stream
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [7:0]         m_axis_tdata,  // [0] alarm_active, [1] above_limit, [2] block_done
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [AddrW-1:0]   paddr,
  input  logic [DataW-1:0]   pwdata,
  output logic [DataW-1:0]   prdata,
  output logic               pready
);

  logic [15:0] thr_q;
  logic [7:0]  spa_q;
  logic [7:0]  cc_q;

  logic        in_valid_q;
  logic [15:0] in_data_q;
  logic        out_valid_q;
  result_t     out_q;

  logic [7:0]  idx_q, idx_d;
  logic [23:0] run_q, run_d;
  logic [23:0] held_q, held_d;
  logic [7:0]  rise_cnt_q, rise_cnt_d;
  logic [7:0]  fall_cnt_q, fall_cnt_d;
  logic [7:0]  rise_el_q, rise_el_d;
  logic [7:0]  fall_el_q, fall_el_d;
  logic        alarm_q, alarm_d;

  logic        adv;
  logic [7:0]  len;
  logic [23:0] sum;
  logic [23:0] limit;
  logic        done_c;
  logic        above_c;
  logic [7:0]  rise_inc, fall_inc, step_cnt;
  logic        cfg_wr;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THRESHOLD_RST;
      spa_q <= SAMPLES_RST;
      cc_q  <= CONFIRM_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_THRESHOLD: thr_q <= pwdata[15:0];
        REG_SAMPLES:   spa_q <= pwdata[7:0];
        REG_CONFIRM:   cc_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD: prdata = {16'd0, thr_q};
      REG_SAMPLES:   prdata = {24'd0, spa_q};
      REG_CONFIRM:   prdata = {24'd0, cc_q};
      default:       prdata = '0;
    endcase
  end

  // handshake: input register, then result register
  assign adv           = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | adv;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, out_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_data_q <= s_axis_tdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.alarm_active <= alarm_d;
      out_q.above_limit  <= above_c;
      out_q.block_done   <= done_c;
    end
  end

  // per-sample update
  always_comb begin
    len      = (spa_q == 8'd0) ? 8'd1 : spa_q;
    sum      = run_q + 24'(in_data_q);
    done_c   = ({1'b0, idx_q} + 9'd1) >= {1'b0, len};
    limit    = 24'(thr_q) * 24'(len);
    rise_inc = sat_inc8(rise_el_q);
    fall_inc = sat_inc8(fall_el_q);

    if (done_c) begin
      held_d = sum;
      run_d  = '0;
      idx_d  = '0;
    end else begin
      held_d = held_q;
      run_d  = sum;
      idx_d  = idx_q + 8'd1;
    end

    above_c    = held_d > limit;
    rise_el_d  = rise_inc;
    fall_el_d  = fall_inc;
    rise_cnt_d = rise_cnt_q;
    fall_cnt_d = fall_cnt_q;
    alarm_d    = alarm_q;
    step_cnt   = '0;

    if (above_c) begin
      fall_cnt_d = '0;
      if (rise_inc >= len) begin
        rise_el_d = '0;
        step_cnt  = sat_inc8(rise_cnt_q);
        if (step_cnt >= cc_q) begin
          rise_cnt_d = cc_q;
          alarm_d    = 1'b1;
        end else begin
          rise_cnt_d = step_cnt;
        end
      end
    end else begin
      rise_cnt_d = '0;
      if (fall_inc >= len) begin
        fall_el_d = '0;
        step_cnt  = sat_inc8(fall_cnt_q);
        if (step_cnt >= cc_q) begin
          fall_cnt_d = cc_q;
          alarm_d    = 1'b0;
        end else begin
          fall_cnt_d = step_cnt;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q      <= '0;
      run_q      <= '0;
      held_q     <= '0;
      rise_cnt_q <= '0;
      fall_cnt_q <= '0;
      rise_el_q  <= '0;
      fall_el_q  <= '0;
      alarm_q    <= 1'b0;
    end else if (adv) begin
      idx_q      <= idx_d;
      run_q      <= run_d;
      held_q     <= held_d;
      rise_cnt_q <= rise_cnt_d;
      fall_cnt_q <= fall_cnt_d;
      rise_el_q  <= rise_el_d;
      fall_el_q  <= fall_el_d;
      alarm_q    <= alarm_d;
    end
  end

  `AOAD_ASSERT(a_alarm_only_on_transfer, clk_i, rst_ni, !adv |=> $stable(alarm_q), "alarm moved")
  `AOAD_ASSERT(a_block_restarts, clk_i, rst_ni, adv && done_c |=> ~|{idx_q, run_q}, "no restart")
  `AOAD_ASSERT(a_result_matches_alarm, clk_i, rst_ni, adv |=> out_q.alarm_active == alarm_q, "alarm")
  `AOAD_ASSERT(a_one_counter_live, clk_i, rst_ni, rise_cnt_q == '0 || fall_cnt_q == '0, "both live")

endmodule
